/* hdl/jsu_pkg.sv */
// Shared types and codes for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    // Error codes
    localparam logic [2:0] ERR_EXPECTED_STRING    = 3'd0;
    localparam logic [2:0] ERR_CONTROL_CHAR       = 3'd1;
    localparam logic [2:0] ERR_UNTERM_ESCAPE      = 3'd2;
    localparam logic [2:0] ERR_UNSUPPORTED_ESCAPE = 3'd3;
    localparam logic [2:0] ERR_INVALID_UNICODE    = 3'd4;
    localparam logic [2:0] ERR_INCOMPLETE_UNICODE = 3'd5;
    localparam logic [2:0] ERR_UNTERM_STRING      = 3'd6;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_end;
    } in_item_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        logic [2:0] err_code;
        logic       last;
    } result_t;

endpackage

/* hdl/jsu_stream_if.sv */
// Valid/ready stream channel carrying one payload per beat.
`timescale 1ns / 1ps

interface jsu_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/json_string_unescape_utf8.sv */
// JSON string literal unescaper emitting UTF-8 bytes, one text byte per beat.
//
//   channel   modport   payload                               role
//   text      sink      in_byte[8], text_end[1]               raw text bytes
//   result    source    kind[2], out_byte[8], err_code[3],    decoded results
//                       last[1]
//
// Each text beat is decoded in the cycle it is accepted and its results (0 to 4)
// land in a result buffer. The buffer drains one result beat per cycle while the result
// side is ready, and an item gives up to 4 results (4 for a surrogate pair).
// A new text beat is taken while the last pending result goes out.
// Reset returns the parser to waiting for an opening quote and empties the buffer.
// A stalled result side holds the buffer and stops text intake while any result
// is still pending.
`timescale 1ns / 1ps

module json_string_unescape_utf8 (
    input  logic                 clk,
    input  logic                 rst_n,
    jsu_stream_if.sink           text,
    jsu_stream_if.source         result
);

    typedef enum logic [3:0] {
        PH_WAIT,
        PH_STRING,
        PH_ESCAPE,
        PH_HEX1,
        PH_WANT_BS,
        PH_WANT_U,
        PH_HEX2,
        PH_SKIP
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [1:0]  dcnt_reg, dcnt_next;
    logic [9:0]  hs_reg, hs_next;

    logic [7:0]  buf_reg [4];
    logic [7:0]  buf_next [4];
    logic [1:0]  bkind_reg, bkind_next;
    logic [2:0]  berr_reg, berr_next;
    logic [2:0]  bcnt_reg, bcnt_next;

    // Results of the current text beat
    logic [2:0]  n_res;
    logic [1:0]  r_kind;
    logic [2:0]  r_err;
    logic [7:0]  r_byte [4];

    logic [7:0]  c;
    logic        e;
    logic        accept;
    logic        pop;
    logic        is_digit;
    logic [3:0]  digit;
    logic [15:0] acc_shift;
    logic [20:0] cp;
    logic        want_utf8;

    assign c      = text.data.in_byte;
    assign e      = text.data.text_end;
    assign pop    = result.valid && result.ready;
    assign text.ready = (bcnt_reg == 3'd0) || ((bcnt_reg == 3'd1) && result.ready);
    assign accept = text.valid && text.ready;

    assign result.valid           = (bcnt_reg != 3'd0);
    assign result.data.kind       = bkind_reg;
    assign result.data.out_byte   = buf_reg[0];
    assign result.data.err_code   = berr_reg;
    assign result.data.last       = (bcnt_reg == 3'd1);

    // Hex digit decode
    always_comb
    begin
        is_digit = 1'b1;
        digit    = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            digit = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            digit = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            digit = 4'(c - 8'h37);
        end
        else
        begin
            is_digit = 1'b0;
        end
    end

    assign acc_shift = {acc_reg[11:0], digit};
    assign cp = (phase_reg == PH_HEX2)
              ? 21'h10000 + {1'b0, hs_reg, acc_shift[9:0]}
              : {5'd0, acc_shift};

    // Parser step
    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        dcnt_next  = dcnt_reg;
        hs_next    = hs_reg;
        n_res      = 3'd0;
        r_kind     = jsu_pkg::KIND_DATA;
        r_err      = 3'd0;
        r_byte[0]  = 8'd0;
        r_byte[1]  = 8'd0;
        r_byte[2]  = 8'd0;
        r_byte[3]  = 8'd0;
        want_utf8  = 1'b0;

        case (phase_reg)
            PH_STRING:
            begin
                if (e)
                begin
                    n_res = 3'd1; r_kind = jsu_pkg::KIND_ERROR;
                    r_err = jsu_pkg::ERR_UNTERM_STRING; phase_next = PH_WAIT;
                end
                else if (c == 8'h22)
                begin
                    n_res = 3'd1; r_kind = jsu_pkg::KIND_DONE; phase_next = PH_WAIT;
                end
                else if (c == 8'h5C)
                begin
                    phase_next = PH_ESCAPE;
                end
                else if (c <= 8'h1F)
                begin
                    n_res = 3'd1; r_kind = jsu_pkg::KIND_ERROR;
                    r_err = jsu_pkg::ERR_CONTROL_CHAR; phase_next = PH_SKIP;
                end
                else
                begin
                    n_res = 3'd1; r_byte[0] = c;
                end
            end
            PH_ESCAPE:
            begin
                if (e)
                begin
                    n_res = 3'd1; r_kind = jsu_pkg::KIND_ERROR;
                    r_err = jsu_pkg::ERR_UNTERM_ESCAPE; phase_next = PH_WAIT;
                end
                else
                begin
                    phase_next = PH_STRING;
                    n_res      = 3'd1;
                    case (c)
                        8'h22, 8'h5C, 8'h2F: r_byte[0] = c;
                        8'h62: r_byte[0] = 8'h08;
                        8'h66: r_byte[0] = 8'h0C;
                        8'h6E: r_byte[0] = 8'h0A;
                        8'h72: r_byte[0] = 8'h0D;
                        8'h74: r_byte[0] = 8'h09;
                        8'h75:
                        begin
                            n_res = 3'd0; phase_next = PH_HEX1;
                            acc_next = 16'd0; dcnt_next = 2'd0;
                        end
                        default:
                        begin
                            r_kind = jsu_pkg::KIND_ERROR;
                            r_err  = jsu_pkg::ERR_UNSUPPORTED_ESCAPE;
                            phase_next = PH_SKIP;
                        end
                    endcase
                end
            end
            PH_HEX1, PH_HEX2:
            begin
                if (e)
                begin
                    n_res = 3'd1; r_kind = jsu_pkg::KIND_ERROR;
                    r_err = jsu_pkg::ERR_INCOMPLETE_UNICODE; phase_next = PH_WAIT;
                end
                else if (!is_digit)
                begin
                    n_res = 3'd1; r_kind = jsu_pkg::KIND_ERROR;
                    r_err = jsu_pkg::ERR_INVALID_UNICODE; phase_next = PH_SKIP;
                end
                else
                begin
                    acc_next = acc_shift;
                    if (dcnt_reg != 2'd3)
                    begin
                        dcnt_next = dcnt_reg + 2'd1;
                    end
                    else
                    begin
                        dcnt_next = 2'd0;
                        if (phase_reg == PH_HEX1)
                        begin
                            if (acc_shift >= 16'hD800 && acc_shift <= 16'hDBFF)
                            begin
                                hs_next    = acc_shift[9:0];
                                phase_next = PH_WANT_BS;
                            end
                            else if (acc_shift >= 16'hDC00 && acc_shift <= 16'hDFFF)
                            begin
                                n_res = 3'd1; r_kind = jsu_pkg::KIND_ERROR;
                                r_err = jsu_pkg::ERR_INVALID_UNICODE;
                                phase_next = PH_SKIP;
                            end
                            else
                            begin
                                phase_next = PH_STRING; want_utf8 = 1'b1;
                            end
                        end
                        else
                        begin
                            if (acc_shift >= 16'hDC00 && acc_shift <= 16'hDFFF)
                            begin
                                phase_next = PH_STRING; want_utf8 = 1'b1;
                            end
                            else
                            begin
                                n_res = 3'd1; r_kind = jsu_pkg::KIND_ERROR;
                                r_err = jsu_pkg::ERR_INVALID_UNICODE;
                                phase_next = PH_SKIP;
                            end
                        end
                    end
                end
            end
            PH_WANT_BS, PH_WANT_U:
            begin
                if (e)
                begin
                    n_res = 3'd1; r_kind = jsu_pkg::KIND_ERROR;
                    r_err = jsu_pkg::ERR_INCOMPLETE_UNICODE; phase_next = PH_WAIT;
                end
                else if (phase_reg == PH_WANT_BS && c == 8'h5C)
                begin
                    phase_next = PH_WANT_U;
                end
                else if (phase_reg == PH_WANT_U && c == 8'h75)
                begin
                    phase_next = PH_HEX2; acc_next = 16'd0; dcnt_next = 2'd0;
                end
                else
                begin
                    n_res = 3'd1; r_kind = jsu_pkg::KIND_ERROR;
                    r_err = jsu_pkg::ERR_INVALID_UNICODE; phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                if (e)
                begin
                    phase_next = PH_WAIT;
                end
                else if (c == 8'h22)
                begin
                    phase_next = PH_STRING;
                end
            end
            default:
            begin
                if (e)
                begin
                    phase_next = PH_WAIT;
                end
                else if (c == 8'h22)
                begin
                    phase_next = PH_STRING;
                end
                else
                begin
                    n_res = 3'd1; r_kind = jsu_pkg::KIND_ERROR;
                    r_err = jsu_pkg::ERR_EXPECTED_STRING; phase_next = PH_SKIP;
                end
            end
        endcase

        // UTF-8 encode the finished code point
        if (want_utf8)
        begin
            if (cp <= 21'h7F)
            begin
                n_res = 3'd1; r_byte[0] = cp[7:0];
            end
            else if (cp <= 21'h7FF)
            begin
                n_res = 3'd2;
                r_byte[0] = {3'b110, cp[10:6]};
                r_byte[1] = {2'b10, cp[5:0]};
            end
            else if (cp <= 21'hFFFF)
            begin
                n_res = 3'd3;
                r_byte[0] = {4'b1110, cp[15:12]};
                r_byte[1] = {2'b10, cp[11:6]};
                r_byte[2] = {2'b10, cp[5:0]};
            end
            else
            begin
                n_res = 3'd4;
                r_byte[0] = {5'b11110, cp[20:18]};
                r_byte[1] = {2'b10, cp[17:12]};
                r_byte[2] = {2'b10, cp[11:6]};
                r_byte[3] = {2'b10, cp[5:0]};
            end
        end
    end

    // Result buffer: load on accept, shift down on each result beat
    always_comb
    begin
        bcnt_next  = bcnt_reg;
        bkind_next = bkind_reg;
        berr_next  = berr_reg;
        for (int i = 0; i < 4; i++)
        begin
            buf_next[i] = buf_reg[i];
        end
        if (accept)
        begin
            bcnt_next  = n_res;
            bkind_next = r_kind;
            berr_next  = r_err;
            for (int i = 0; i < 4; i++)
            begin
                buf_next[i] = r_byte[i];
            end
        end
        else if (pop)
        begin
            bcnt_next = bcnt_reg - 3'd1;
            for (int i = 0; i < 3; i++)
            begin
                buf_next[i] = buf_reg[i + 1];
            end
            buf_next[3] = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_WAIT;
            acc_reg   <= 16'd0;
            dcnt_reg  <= 2'd0;
            hs_reg    <= 10'd0;
            bcnt_reg  <= 3'd0;
            bkind_reg <= jsu_pkg::KIND_DATA;
            berr_reg  <= 3'd0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                dcnt_reg  <= dcnt_next;
                hs_reg    <= hs_next;
            end
            bcnt_reg  <= bcnt_next;
            bkind_reg <= bkind_next;
            berr_reg  <= berr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
        begin
            buf_reg[i] <= buf_next[i];
        end
    end

    // Buffer never holds more than one surrogate pair's worth of bytes
    a_bcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        bcnt_reg <= 3'd4)
        else $error("result buffer count out of range");

    // Done and error results stand alone
    a_single_nondata: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.kind != jsu_pkg::KIND_DATA) |-> result.data.last)
        else $error("non-data result not marked last");

    // A non-final result beat is followed by another
    a_more_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !result.data.last) |=> result.valid)
        else $error("result sequence cut short");

    // Text intake stalls while more than one result is pending
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (bcnt_reg > 3'd1) |-> !text.ready)
        else $error("text accepted over pending results");

endmodule

/* sim/unescape_check.sv */
// Result checker for the JSON string unescaper: decodes accepted text beats and compares results.
`timescale 1ns / 1ps

module unescape_check
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              text_valid,
    input  logic              text_ready,
    input  jsu_pkg::in_item_t text_data,
    input  logic              result_valid,
    input  logic              result_ready,
    input  jsu_pkg::result_t  result_data,
    output int                mismatches,
    output int                open_results
);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [3:0] {
        LEX_OUTSIDE,
        LEX_BODY,
        LEX_ESCAPE,
        LEX_HEX_HIGH,
        LEX_WANT_BSLASH,
        LEX_WANT_U,
        LEX_HEX_LOW,
        LEX_DISCARD
    } lex_phase_e;

    lex_phase_e  lex_phase;
    logic [15:0] hex_word;
    logic [1:0]  digits_seen;
    logic [9:0]  high_half;

    jsu_pkg::result_t decoded_queue[$];
    jsu_pkg::result_t beat_results [0:3];
    int               beat_count;

    initial mismatches = 0;

    function automatic int nibble_of(input logic [7:0] c);
        if (c >= "0" && c <= "9")
        begin
            return int'(c - "0");
        end
        if (c >= "a" && c <= "f")
        begin
            return int'(c - "a") + 10;
        end
        if (c >= "A" && c <= "F")
        begin
            return int'(c - "A") + 10;
        end
        return -1;
    endfunction

    task automatic add_result(input logic [1:0] k, input logic [7:0] b, input logic [2:0] e);
        beat_results[beat_count] = {k, b, e, 1'b0};
        beat_count++;
    endtask

    task automatic raise_error(input logic [2:0] code, input bit at_end);
        // an error at text end goes straight back to waiting for a quote
        lex_phase = at_end ? LEX_OUTSIDE : LEX_DISCARD;
        add_result(jsu_pkg::KIND_ERROR, 8'h00, code);
    endtask

    task automatic add_utf8(input logic [20:0] cp);
        if (cp <= 21'h7F)
        begin
            add_result(jsu_pkg::KIND_DATA, cp[7:0], 3'd0);
        end
        else if (cp <= 21'h7FF)
        begin
            add_result(jsu_pkg::KIND_DATA, {3'b110, cp[10:6]}, 3'd0);
            add_result(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, 3'd0);
        end
        else if (cp <= 21'hFFFF)
        begin
            add_result(jsu_pkg::KIND_DATA, {4'b1110, cp[15:12]}, 3'd0);
            add_result(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]}, 3'd0);
            add_result(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, 3'd0);
        end
        else
        begin
            add_result(jsu_pkg::KIND_DATA, {5'b11110, cp[20:18]}, 3'd0);
            add_result(jsu_pkg::KIND_DATA, {2'b10, cp[17:12]}, 3'd0);
            add_result(jsu_pkg::KIND_DATA, {2'b10, cp[11:6]}, 3'd0);
            add_result(jsu_pkg::KIND_DATA, {2'b10, cp[5:0]}, 3'd0);
        end
    endtask

    task automatic decode_text_beat(input jsu_pkg::in_item_t beat);
        logic [7:0]  c;
        bit          fin;
        int          nib;
        logic [20:0] cp;
        c = beat.in_byte;
        fin = beat.text_end;
        beat_count = 0;
        case (lex_phase)
            LEX_BODY:
            begin
                if (fin)
                    raise_error(jsu_pkg::ERR_UNTERM_STRING, 1'b1);
                else if (c == CH_QUOTE)
                begin
                    lex_phase = LEX_OUTSIDE;
                    add_result(jsu_pkg::KIND_DONE, 8'h00, 3'd0);
                end
                else if (c == CH_BSLASH)
                    lex_phase = LEX_ESCAPE;
                else if (c <= 8'h1F)
                    raise_error(jsu_pkg::ERR_CONTROL_CHAR, 1'b0);
                else
                    add_result(jsu_pkg::KIND_DATA, c, 3'd0);
            end
            LEX_ESCAPE:
            begin
                if (fin)
                    raise_error(jsu_pkg::ERR_UNTERM_ESCAPE, 1'b1);
                else
                begin
                    lex_phase = LEX_BODY;
                    case (c)
                        CH_QUOTE, CH_BSLASH, "/": add_result(jsu_pkg::KIND_DATA, c, 3'd0);
                        "b": add_result(jsu_pkg::KIND_DATA, 8'h08, 3'd0);
                        "f": add_result(jsu_pkg::KIND_DATA, 8'h0C, 3'd0);
                        "n": add_result(jsu_pkg::KIND_DATA, 8'h0A, 3'd0);
                        "r": add_result(jsu_pkg::KIND_DATA, 8'h0D, 3'd0);
                        "t": add_result(jsu_pkg::KIND_DATA, 8'h09, 3'd0);
                        "u":
                        begin
                            lex_phase = LEX_HEX_HIGH;
                            hex_word = 16'h0000;
                            digits_seen = 2'd0;
                        end
                        default: raise_error(jsu_pkg::ERR_UNSUPPORTED_ESCAPE, 1'b0);
                    endcase
                end
            end
            LEX_HEX_HIGH, LEX_HEX_LOW:
            begin
                nib = nibble_of(c);
                if (fin)
                    raise_error(jsu_pkg::ERR_INCOMPLETE_UNICODE, 1'b1);
                else if (nib < 0)
                    raise_error(jsu_pkg::ERR_INVALID_UNICODE, 1'b0);
                else
                begin
                    hex_word = {hex_word[11:0], nib[3:0]};
                    if (digits_seen != 2'd3)
                        digits_seen++;
                    else
                    begin
                        digits_seen = 2'd0;
                        if (lex_phase == LEX_HEX_HIGH)
                        begin
                            if (hex_word >= 16'hD800 && hex_word <= 16'hDBFF)
                            begin
                                // D800 is aligned, so the offset is the low ten bits
                                high_half = hex_word[9:0];
                                lex_phase = LEX_WANT_BSLASH;
                            end
                            else if (hex_word >= 16'hDC00 && hex_word <= 16'hDFFF)
                                raise_error(jsu_pkg::ERR_INVALID_UNICODE, 1'b0);
                            else
                            begin
                                lex_phase = LEX_BODY;
                                add_utf8({5'd0, hex_word});
                            end
                        end
                        else if (hex_word >= 16'hDC00 && hex_word <= 16'hDFFF)
                        begin
                            cp = 21'h10000 + {1'b0, high_half, hex_word[9:0]};
                            lex_phase = LEX_BODY;
                            add_utf8(cp);
                        end
                        else
                            raise_error(jsu_pkg::ERR_INVALID_UNICODE, 1'b0);
                    end
                end
            end
            LEX_WANT_BSLASH:
            begin
                if (fin)
                    raise_error(jsu_pkg::ERR_INCOMPLETE_UNICODE, 1'b1);
                else if (c == CH_BSLASH)
                    lex_phase = LEX_WANT_U;
                else
                    raise_error(jsu_pkg::ERR_INVALID_UNICODE, 1'b0);
            end
            LEX_WANT_U:
            begin
                if (fin)
                    raise_error(jsu_pkg::ERR_INCOMPLETE_UNICODE, 1'b1);
                else if (c == "u")
                begin
                    lex_phase = LEX_HEX_LOW;
                    hex_word = 16'h0000;
                    digits_seen = 2'd0;
                end
                else
                    raise_error(jsu_pkg::ERR_INVALID_UNICODE, 1'b0);
            end
            LEX_DISCARD:
            begin
                if (fin)
                    lex_phase = LEX_OUTSIDE;
                else if (c == CH_QUOTE)
                    lex_phase = LEX_BODY;
            end
            default:
            begin
                if (fin)
                    lex_phase = LEX_OUTSIDE;
                else if (c == CH_QUOTE)
                    lex_phase = LEX_BODY;
                else
                    raise_error(jsu_pkg::ERR_EXPECTED_STRING, 1'b0);
            end
        endcase
        for (int i = 0; i < beat_count; i++)
        begin
            beat_results[i].last = (i == beat_count - 1);
            decoded_queue = {decoded_queue, beat_results[i]};
        end
    endtask

    task automatic compare_result(input jsu_pkg::result_t got);
        jsu_pkg::result_t want;
        if (decoded_queue.size() == 0)
        begin
            $error("unexpected result: kind %0d out_byte %02h err_code %0d last %0d",
                   got.kind, got.out_byte, got.err_code, got.last);
            mismatches++;
        end
        else
        begin
            want = decoded_queue.pop_front();
            if (got.kind !== want.kind)
            begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                mismatches++;
            end
            if (got.out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
                mismatches++;
            end
            if (got.err_code !== want.err_code)
            begin
                $error("err_code: expected %0d, got %0d", want.err_code, got.err_code);
                mismatches++;
            end
            if (got.last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lex_phase = LEX_OUTSIDE;
            hex_word = 16'h0000;
            digits_seen = 2'd0;
            high_half = 10'd0;
            decoded_queue.delete();
        end
        else
        begin
            // decode first; this beat's results reach the result side only once registered in the buffer
            if (text_valid && text_ready)
                decode_text_beat(text_data);
            if (result_valid && result_ready)
                compare_result(result_data);
        end
        open_results = decoded_queue.size();
    end

endmodule

/* sim/testbench.sv */
// Top-level testbench for the JSON string unescaper: clock, reset, text stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int RANDOM_ITEMS = 400;
    localparam int CALM_TAIL    = 60;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    logic clk;
    logic rst_n;

    jsu_stream_if #(.payload_t(jsu_pkg::in_item_t)) text_bus ();
    jsu_stream_if #(.payload_t(jsu_pkg::result_t))  result_bus ();

    int    mismatches;
    int    open_results;
    int    sent;
    int    stop_at;
    bit    calm;
    string escape_letters = "\"\\/bfnrt";

    json_string_unescape_utf8 uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_bus),
        .result (result_bus)
    );

    unescape_check unescape_check_i (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_valid   (text_bus.valid),
        .text_ready   (text_bus.ready),
        .text_data    (text_bus.data),
        .result_valid (result_bus.valid),
        .result_ready (result_bus.ready),
        .result_data  (result_bus.data),
        .mismatches   (mismatches),
        .open_results (open_results)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    // result side: random stall bursts, none in the tail of the run
    initial
    begin
        result_bus.ready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                result_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                result_bus.ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
        if (n < 4'd10)
            return 8'h30 + n;
        return (upper ? 8'h41 : 8'h61) + n - 8'd10;
    endfunction

    function automatic bit is_hex_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic bit is_escape_letter(input logic [7:0] c);
        case (c)
            CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t", "u": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic [15:0] random_bmp();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(0, 16'h007F));
            1: return 16'($urandom_range(16'h0080, 16'h07FF));
            2: return 16'($urandom_range(16'h0800, 16'hD7FF));
            default: return 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
    endfunction

    task automatic send_beat(input logic [7:0] b, input logic fin);
        if (!calm && $urandom_range(0, 9) == 0)
        begin
            text_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        text_bus.valid <= 1'b1;
        text_bus.data  <= {b, fin};
        do
            @(posedge clk);
        while (!text_bus.ready);
        sent++;
        calm = (stop_at > 0) && (sent >= stop_at - CALM_TAIL);
    endtask

    task automatic send_end();
        send_beat(8'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_beat(s[i], 1'b0);
    endtask

    task automatic send_hex_digits(input logic [15:0] v, input int count);
        for (int i = 0; i < count; i++)
            send_beat(hex_char(v[15 - 4 * i -: 4], 1'($urandom_range(0, 1))), 1'b0);
    endtask

    task automatic send_u_escape(input logic [15:0] v);
        send_beat(CH_BSLASH, 1'b0);
        send_beat("u", 1'b0);
        send_hex_digits(v, 4);
    endtask

    // hold the text side until every expected result is out
    task automatic drain_results();
        text_bus.valid <= 1'b0;
        do
            @(negedge clk);
        while (open_results != 0);
        @(posedge clk);
    endtask

    task automatic send_high_surrogate();
        send_u_escape(16'($urandom_range(16'hD800, 16'hDBFF)));
    endtask

    task automatic send_broken_tail();
        logic [7:0] b;
        case ($urandom_range(0, 9))
            0: send_beat(8'($urandom_range(0, 8'h1F)), 1'b0);
            1:
            begin
                send_beat(CH_BSLASH, 1'b0);
                do
                    b = 8'($urandom_range(0, 255));
                while (is_escape_letter(b));
                send_beat(b, 1'b0);
            end
            2:
            begin
                send_beat(CH_BSLASH, 1'b0);
                send_end();
            end
            3:
            begin
                send_beat(CH_BSLASH, 1'b0);
                send_beat("u", 1'b0);
                send_hex_digits(16'($urandom), $urandom_range(0, 3));
                do
                    b = 8'($urandom_range(0, 255));
                while (is_hex_char(b));
                send_beat(b, 1'b0);
            end
            4:
            begin
                send_beat(CH_BSLASH, 1'b0);
                send_beat("u", 1'b0);
                send_hex_digits(16'($urandom), $urandom_range(0, 3));
                send_end();
            end
            5: send_u_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
            6:
            begin
                send_high_surrogate();
                do
                    b = 8'($urandom_range(0, 255));
                while (b == CH_BSLASH);
                send_beat(b, 1'b0);
            end
            7:
            begin
                send_high_surrogate();
                send_beat(CH_BSLASH, 1'b0);
                do
                    b = 8'($urandom_range(0, 255));
                while (b == "u");
                send_beat(b, 1'b0);
            end
            8:
            begin
                send_high_surrogate();
                if ($urandom_range(0, 1) == 0)
                    send_u_escape(random_bmp());
                else
                    send_high_surrogate();
            end
            default:
            begin
                send_high_surrogate();
                case ($urandom_range(0, 2))
                    0: send_end();
                    1:
                    begin
                        send_beat(CH_BSLASH, 1'b0);
                        send_end();
                    end
                    default:
                    begin
                        send_beat(CH_BSLASH, 1'b0);
                        send_beat("u", 1'b0);
                        send_hex_digits(16'($urandom_range(16'hDC00, 16'hDFFF)),
                                        $urandom_range(0, 3));
                        send_end();
                    end
                endcase
            end
        endcase
    endtask

    task automatic send_random_string();
        int         segments;
        int         pick;
        bit         broken;
        logic [7:0] b;
        broken = 1'b0;
        send_beat(CH_QUOTE, 1'b0);
        segments = $urandom_range(0, 8);
        for (int i = 0; i < segments && !broken; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
            begin
                do
                    b = 8'($urandom_range(8'h20, 8'hFF));
                while (b == CH_QUOTE || b == CH_BSLASH);
                send_beat(b, 1'b0);
            end
            else if (pick < 55)
            begin
                send_beat(CH_BSLASH, 1'b0);
                send_beat(escape_letters[$urandom_range(0, 7)], 1'b0);
            end
            else if (pick < 75)
                send_u_escape(random_bmp());
            else if (pick < 88)
            begin
                send_high_surrogate();
                send_u_escape(16'($urandom_range(16'hDC00, 16'hDFFF)));
            end
            else
            begin
                send_broken_tail();
                broken = 1'b1;
            end
        end
        if (!broken)
        begin
            if ($urandom_range(0, 19) == 0)
                send_end();
            else
                send_beat(CH_QUOTE, 1'b0);
        end
    endtask

    initial
    begin
        int strings_sent;
        int noise;
        strings_sent = 0;
        sent = 0;
        stop_at = 0;
        calm = 1'b0;
        rst_n <= 1'b0;
        text_bus.valid <= 1'b0;
        text_bus.data  <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // stray byte before a string, discard, text end while discarding and while waiting
        send_text("x");
        send_text("a");
        send_end();
        send_end();
        // byte extremes, a surrogate pair, a short escape, then a control byte
        send_beat(CH_QUOTE, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h20, 1'b0);
        send_text("\\uD83D\\uDE00");
        send_text("\\n");
        send_beat(8'h00, 1'b0);
        // quote out of discard, escaped NUL, close
        send_text("\"\\u0000\"");
        drain_results();

        stop_at = sent + RANDOM_ITEMS;
        while (sent < stop_at)
        begin
            noise = $urandom_range(0, 19);
            if (noise < 2)
                send_end();
            else if (noise < 4)
                repeat ($urandom_range(1, 3)) send_beat(8'($urandom_range(0, 255)), 1'b0);
            send_random_string();
            strings_sent++;
            if (strings_sent == 12)
                drain_results();
        end

        drain_results();
        repeat (20) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0 && open_results == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
